// File: src/html_tag_strip_entity_decode_assert.svh
`ifndef HTML_TAG_STRIP_ENTITY_DECODE_ASSERT_SVH
`define HTML_TAG_STRIP_ENTITY_DECODE_ASSERT_SVH

// Checks that a condition implies another one in the same cycle.
`define HTSED_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("html tag strip: same-cycle check failed");

// Checks that a condition implies another one in the following cycle.
`define HTSED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("html tag strip: next-cycle check failed");

`endif

// File: src/htsed_pkg.sv
package htsed_pkg;

  localparam logic [7:0] CharLt    = 8'h3C;
  localparam logic [7:0] CharGt    = 8'h3E;
  localparam logic [7:0] CharAmp   = 8'h26;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharSpace = 8'h20;

  // Longest entity body that is still collected.
  localparam logic [3:0] EntityMaxLen = 4'd10;

  localparam int unsigned NumEntities = 8;

  typedef struct packed {
    logic [3:0]  len;
    logic [31:0] name;
    logic [7:0]  result;
  } entity_entry_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } entity_hit_t;

  // Names are packed with the first body byte in the low byte.
  localparam entity_entry_t EntityTable [NumEntities] = '{
    '{len: 4'd3, name: 32'h0070_6D61, result: 8'h26},
    '{len: 4'd4, name: 32'h746F_7571, result: 8'h22},
    '{len: 4'd2, name: 32'h0000_746C, result: 8'h3C},
    '{len: 4'd2, name: 32'h0000_7467, result: 8'h3E},
    '{len: 4'd4, name: 32'h736F_7061, result: 8'h27},
    '{len: 4'd4, name: 32'h3732_7823, result: 8'h27},
    '{len: 4'd3, name: 32'h0039_3323, result: 8'h27},
    '{len: 4'd4, name: 32'h7073_626E, result: 8'h20}
  };

  function automatic entity_hit_t entity_lookup(input logic [3:0] len,
                                                input logic [31:0] head);
    entity_hit_t r;
    r = '0;
    for (int k = 0; k < NumEntities; k++) begin
      if (len == EntityTable[k].len && head == EntityTable[k].name) begin
        r.hit = 1'b1;
        r.ch  = EntityTable[k].result;
      end
    end
    return r;
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return c inside {CharSpace, [8'h09:8'h0D]};
  endfunction

endpackage

// File: src/html_tag_strip_entity_decode.sv
// HTML to plain text byte filter with entity decoding.
// Input channel: in_valid / in_stall carry one request per page byte
// (in_byte, start_of_page). Output channel: out_valid / out_stall carry one
// plain-text byte (out_byte). A request yields zero or one output byte.
// A request is registered when accepted; from the input register, tags,
// entities and whitespace collapsing are resolved in one pass against the
// parse state and the result is written to the output register, which raises
// out_valid when a byte is emitted. One request per cycle is sustained while
// the receiver does not stall; a single parse-state update is made per byte.
// When the receiver stalls with a byte waiting, the input register holds its
// request and in_stall rises in the same cycle; no request is lost.
// Reset (rst, synchronous) empties both registers and returns the parse state
// to its start-of-page values; start_of_page set on a request does the same
// for the parse state just before that byte is handled.
// Whitespace is always emitted as 0x20, at most once in a row, and never at
// the start of a page.
module html_tag_strip_entity_decode (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       start_of_page,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte
);
  import htsed_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_sop;

  logic        inside_tag, inside_tag_next;
  logic        previous_was_space, previous_was_space_next;
  logic        inside_entity, inside_entity_next;
  logic [3:0]  entity_length, entity_length_next;
  logic [31:0] entity_head_chars, entity_head_chars_next;

  logic        advance;
  logic        emit;
  logic [7:0]  emit_char;
  logic        cand_valid;
  logic [7:0]  cand_char;
  entity_hit_t hit;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_byte <= in_byte;
      s1_sop  <= start_of_page;
    end
  end

  always_comb begin
    // Start of page restores the parse state before the byte is handled.
    inside_tag_next         = s1_sop ? 1'b0 : inside_tag;
    previous_was_space_next = s1_sop ? 1'b1 : previous_was_space;
    inside_entity_next      = s1_sop ? 1'b0 : inside_entity;
    entity_length_next      = s1_sop ? 4'd0 : entity_length;
    entity_head_chars_next  = s1_sop ? 32'd0 : entity_head_chars;
    cand_valid = 1'b0;
    cand_char  = s1_byte;
    emit       = 1'b0;
    emit_char  = s1_byte;
    hit        = entity_lookup(entity_length_next, entity_head_chars_next);

    if (inside_entity_next) begin
      if (s1_byte == CharSemi) begin
        cand_valid = hit.hit;
        cand_char  = hit.ch;
        inside_entity_next     = 1'b0;
        entity_length_next     = 4'd0;
        entity_head_chars_next = 32'd0;
      end else if (entity_length_next >= EntityMaxLen) begin
        inside_entity_next     = 1'b0;
        entity_length_next     = 4'd0;
        entity_head_chars_next = 32'd0;
      end else begin
        if (entity_length_next < 4'd4) begin
          entity_head_chars_next[{entity_length_next[1:0], 3'b000} +: 8] = s1_byte;
        end
        entity_length_next = entity_length_next + 4'd1;
      end
    end else if (s1_byte == CharLt) begin
      inside_tag_next = 1'b1;
    end else if (s1_byte == CharGt) begin
      inside_tag_next = 1'b0;
    end else if (!inside_tag_next) begin
      if (s1_byte == CharAmp) begin
        inside_entity_next     = 1'b1;
        entity_length_next     = 4'd0;
        entity_head_chars_next = 32'd0;
      end else begin
        cand_valid = 1'b1;
      end
    end

    if (cand_valid) begin
      if (is_white(cand_char)) begin
        if (!previous_was_space_next) begin
          emit      = 1'b1;
          emit_char = CharSpace;
          previous_was_space_next = 1'b1;
        end
      end else begin
        emit      = 1'b1;
        emit_char = cand_char;
        previous_was_space_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag         <= 1'b0;
      previous_was_space <= 1'b1;
      inside_entity      <= 1'b0;
      entity_length      <= 4'd0;
      entity_head_chars  <= 32'd0;
      out_valid          <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && emit;
      if (s1_valid) begin
        inside_tag         <= inside_tag_next;
        previous_was_space <= previous_was_space_next;
        inside_entity      <= inside_entity_next;
        entity_length      <= entity_length_next;
        entity_head_chars  <= entity_head_chars_next;
      end
    end
    if (advance && s1_valid && emit) begin
      out_byte <= emit_char;
    end
  end

`include "html_tag_strip_entity_decode_assert.svh"

  `HTSED_ASSERT_SAME(a_space_marks_state, out_valid && out_byte == CharSpace, previous_was_space)
  `HTSED_ASSERT_SAME(a_text_clears_space, out_valid && out_byte != CharSpace, !previous_was_space)
  `HTSED_ASSERT_SAME(a_entity_idle_clear, !inside_entity, entity_length == 4'd0 && entity_head_chars == 32'd0)
  `HTSED_ASSERT_NEXT(a_hold_on_stall, s1_valid && out_valid && out_stall, s1_valid && $stable(s1_byte) && $stable(s1_sop))

endmodule
